// ----- sv/bklt_pkg.sv -----
package bklt_pkg;

   // default number of entries in the table
   localparam int DEFAULT_DEPTH = 16;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_SEARCH = 2'd2,
      OP_LIST   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STATUS_DONE      = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_NOT_FOUND = 2'd2,
      STATUS_EMPTY     = 2'd3
   } status_type;

   // one stored entry
   typedef struct packed {
      logic [63:0]        name;
      logic [63:0]        kind;
      logic signed [31:0] quantity;
   } entry_type;

   // request transaction
   typedef struct packed {
      op_type             operation;
      logic [63:0]        item_name;
      logic [63:0]        item_kind;
      logic signed [31:0] item_quantity;
   } req_type;

   // response transaction
   typedef struct packed {
      status_type         status;
      logic [4:0]         entry_position;
      logic [63:0]        entry_name;
      logic [63:0]        entry_kind;
      logic signed [31:0] entry_quantity;
      logic               last_result;
   } rsp_type;

   // control shared by all cells of the chain
   typedef struct packed {
      logic insert;  // write the new entry into the cell at the fill level
      logic shift;   // move every entry one cell toward the head
      logic wrap;    // tail cell takes the head entry (ring rotation)
   } cell_ctrl_type;

endpackage

// ----- sv/bklt_cell.sv -----
// One table slot. Loads a new entry when it sits at the fill level, and on a
// shift takes its neighbor's entry, or the head entry when it is the tail of
// the ring and wrap is set.
module bklt_cell #(
   parameter int INDEX = 0,
   parameter int CW    = 5
) (
   input  logic                   clock,
   input  bklt_pkg::cell_ctrl_type ctrl,
   input  logic [CW-1:0]          fill,
   input  logic [CW-1:0]          tail,
   input  bklt_pkg::entry_type    ins_entry,
   input  bklt_pkg::entry_type    head_entry,
   input  bklt_pkg::entry_type    next_entry,
   output bklt_pkg::entry_type    entry
);

   bklt_pkg::entry_type entry_ff;
   bklt_pkg::entry_type entry_in;

   // next entry of this slot
   always_comb begin
      entry_in = entry_ff;
      if (ctrl.insert && (fill == CW'(INDEX))) begin
         entry_in = ins_entry;
      end else if (ctrl.shift) begin
         if (ctrl.wrap && (tail == CW'(INDEX))) begin
            entry_in = head_entry;
         end else begin
            entry_in = next_entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

// ----- sv/bounded_keyed_list_table_core.sv -----
// Bounded keyed list table. Entries sit in a chain of cells in insertion
// order. Insert, and any command that finds the table full or empty, is done
// in its accept cycle: busy stays low, the next transaction can be taken at
// the following edge, and the response strobes in the cycle after the accept.
// Search, remove and list take the accept cycle, then a scan step for each
// entry held at the start, with busy high. In each scan cycle the chain
// rotates one place past the head cell, where the key is compared, and after
// a rotation for each starting entry the order is restored (remove drops the
// first match on the way). Each response strobes in the cycle after the scan
// step that produced it: a list gives one per cycle; search and remove give
// one, after the matching step or, with no match, after the last one.
// Responses cannot be held off: each is valid for exactly one cycle and must
// be taken then.
module bounded_keyed_list_table_core #(
   parameter int TABLE_DEPTH = bklt_pkg::DEFAULT_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  bklt_pkg::req_type req_data,
   output logic              rsp_strobe,
   output bklt_pkg::rsp_type rsp_data
);

   localparam int CW = $clog2(TABLE_DEPTH + 1);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } state_type;

   state_type          state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      step_ff, step_in;
   logic [CW-1:0]      total_ff, total_in;
   logic               found_ff, found_in;
   bklt_pkg::op_type   op_ff, op_in;
   logic [63:0]        key_ff, key_in;
   logic               rsp_strobe_ff, rsp_strobe_in;
   bklt_pkg::rsp_type  rsp_data_ff, rsp_data_in;

   bklt_pkg::cell_ctrl_type ctrl;
   bklt_pkg::entry_type     ins_entry;
   bklt_pkg::entry_type     cell_entry [TABLE_DEPTH];
   bklt_pkg::entry_type     head;
   logic [CW-1:0]           tail;
   logic [CW:0]             pos_wide;
   logic                    hit;
   logic                    last_step;

   function automatic bklt_pkg::rsp_type status_rsp(input bklt_pkg::status_type st);
      bklt_pkg::rsp_type r;
      r                = '0;
      r.status         = st;
      r.last_result    = 1'b1;
      return r;
   endfunction

   // cell chain
   assign head = cell_entry[0];
   assign tail = count_ff - CW'(1);
   assign ins_entry.name     = req_data.item_name;
   assign ins_entry.kind     = req_data.item_kind;
   assign ins_entry.quantity = req_data.item_quantity;

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      bklt_pkg::entry_type next_entry;
      if (i == TABLE_DEPTH - 1) begin : g_end
         assign next_entry = cell_entry[0];
      end else begin : g_mid
         assign next_entry = cell_entry[i+1];
      end
      bklt_cell #(
         .INDEX(i),
         .CW   (CW)
      ) u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .fill      (count_ff),
         .tail      (tail),
         .ins_entry (ins_entry),
         .head_entry(cell_entry[0]),
         .next_entry(next_entry),
         .entry     (cell_entry[i])
      );
   end

   // key compare at the head cell during a scan
   assign hit       = !found_ff && (op_ff != bklt_pkg::OP_LIST) && (head.name == key_ff);
   assign last_step = (step_ff == total_ff - CW'(1));
   assign pos_wide  = {1'b0, step_ff} + (CW+1)'(1);

   // command sequencer
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      step_in       = step_ff;
      total_in      = total_ff;
      found_in      = found_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = rsp_data_ff;
      ctrl          = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in  = req_data.operation;
               key_in = req_data.item_name;
               case (req_data.operation)
                  bklt_pkg::OP_INSERT: begin
                     rsp_strobe_in = 1'b1;
                     if (count_ff == CW'(TABLE_DEPTH)) begin
                        rsp_data_in = status_rsp(bklt_pkg::STATUS_FULL);
                     end else begin
                        ctrl.insert                = 1'b1;
                        count_in                   = count_ff + CW'(1);
                        rsp_data_in.status         = bklt_pkg::STATUS_DONE;
                        rsp_data_in.entry_position = 5'({1'b0, count_ff} + (CW+1)'(1));
                        rsp_data_in.entry_name     = req_data.item_name;
                        rsp_data_in.entry_kind     = req_data.item_kind;
                        rsp_data_in.entry_quantity = req_data.item_quantity;
                        rsp_data_in.last_result    = 1'b1;
                     end
                  end
                  default: begin
                     if (count_ff == '0) begin
                        rsp_strobe_in = 1'b1;
                        rsp_data_in   = status_rsp(
                           (req_data.operation == bklt_pkg::OP_LIST) ?
                           bklt_pkg::STATUS_EMPTY : bklt_pkg::STATUS_NOT_FOUND);
                     end else begin
                        state_in = ST_SCAN;
                        step_in  = '0;
                        total_in = count_ff;
                        found_in = 1'b0;
                     end
                  end
               endcase
            end
         end
         ST_SCAN: begin
            // rotate the ring; a remove hit leaves the head out of it
            ctrl.shift = 1'b1;
            ctrl.wrap  = !(hit && (op_ff == bklt_pkg::OP_REMOVE));
            step_in    = step_ff + CW'(1);
            if ((op_ff == bklt_pkg::OP_LIST) || hit) begin
               rsp_strobe_in              = 1'b1;
               rsp_data_in.status         = bklt_pkg::STATUS_DONE;
               rsp_data_in.entry_position = 5'(pos_wide);
               rsp_data_in.entry_name     = head.name;
               rsp_data_in.entry_kind     = head.kind;
               rsp_data_in.entry_quantity = head.quantity;
               rsp_data_in.last_result    = hit || last_step;
            end
            if (hit) begin
               found_in = 1'b1;
               if (op_ff == bklt_pkg::OP_REMOVE) begin
                  count_in = count_ff - CW'(1);
               end
            end
            if (last_step) begin
               state_in = ST_IDLE;
               if ((op_ff != bklt_pkg::OP_LIST) && !found_ff && !hit) begin
                  rsp_strobe_in = 1'b1;
                  rsp_data_in   = status_rsp(bklt_pkg::STATUS_NOT_FOUND);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
         found_ff      <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
         found_ff      <= found_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      step_ff     <= step_in;
      total_ff    <= total_in;
      op_ff       <= op_in;
      key_ff      <= key_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

`ifndef SYNTHESIS
   // the fill level never passes the table depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(TABLE_DEPTH))
      else $error("entry count beyond table depth");

   // a scan never runs past the entries it started with
   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (step_ff < total_ff) && (total_ff != '0))
      else $error("scan step out of range");

   // a list of a non-empty table keeps the block busy next cycle
   a_list_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_data.operation == bklt_pkg::OP_LIST) && (count_ff != '0))
      |=> busy)
      else $error("list did not start a scan");

   // a remove hit shrinks the table by one
   a_remove_shrink: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SCAN) && hit && (op_ff == bklt_pkg::OP_REMOVE))
      |=> (count_ff == $past(count_ff) - CW'(1)))
      else $error("remove did not drop an entry");

   // status-only responses carry no entry and close the command
   a_status_rsp: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_data.status != bklt_pkg::STATUS_DONE))
      |-> (rsp_data.entry_position == 5'd0) && rsp_data.last_result)
      else $error("malformed status response");
`endif

endmodule
